// ----- rtl/core/lbcs_pkg.sv -----
// Shared types and constants for the LED blink code sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lbcs_pkg;

	localparam int unsigned CODE_W  = 4;
	localparam int unsigned REP_W   = 8;
	localparam int unsigned TICKS_W = 16;

	// func field codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_ON    = 5'b00010,
		PH_OFF   = 5'b00100,
		PH_PAUSE = 5'b01000,
		PH_IDLE  = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbcs_if.sv -----
// Valid/ready channels of the LED blink code sequencer: command words in, status words out.
`timescale 1ns / 1ps
`default_nettype none

interface lbcs_in_if import lbcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [CODE_W-1:0]  code;
	logic [REP_W-1:0]   repeats;
	logic [TICKS_W-1:0] on_ticks;
	logic [TICKS_W-1:0] off_ticks;
	logic [TICKS_W-1:0] pause_ticks;

	modport source (
		output valid, func, code, repeats, on_ticks, off_ticks, pause_ticks,
		input  ready
	);
	modport sink (
		input  valid, func, code, repeats, on_ticks, off_ticks, pause_ticks,
		output ready
	);
endinterface

interface lbcs_out_if;
	logic valid;
	logic ready;
	logic led_on;
	logic busy_res;

	modport source (
		output valid, led_on, busy_res,
		input  ready
	);
	modport sink (
		input  valid, led_on, busy_res,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/led_blink_code_sequencer.sv -----
// LED blink code sequencer: load and tick words in, LED level and busy status out.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   cmd : command words. func = load stores code, repeats and the on, off and
//         pause tick counts and restarts the sequence at the start phase;
//         func = tick advances the sequence by one step.
//   rsp : one status word per command word: LED level and busy flag after it.
//   Each timed phase lasts its count plus one ticks; code 0 switches the LED
//   off and ends the sequence; repeats 0 loops for ever, busy dropping at the
//   end of each pause. Loaded counts keep their low TIMER_WIDTH bits.
// Timing
//   A word is taken into the input register; from there the sequencer state
//   and the status register are updated when rsp is not stalled, and the
//   status register holds the status word until rsp takes it.
//   One word per cycle sustained while rsp is not stalled: the whole step is a
//   single pass of compare/decrement logic.
// Reset
//   arst_n clears the sequencer to idle, LED off, busy low, both stages empty.
// Back-pressure
//   While rsp is stalled the status word holds and the input register still
//   takes one more word; cmd.ready drops only when both are full.

module led_blink_code_sequencer
	import lbcs_pkg::*;
#(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	lbcs_in_if.sink     cmd,
	lbcs_out_if.source  rsp
);

	// input stage
	logic               valid_s1;
	logic               func_s1;
	logic [CODE_W-1:0]  code_s1;
	logic [REP_W-1:0]   repeats_s1;
	logic [TICKS_W-1:0] on_s1;
	logic [TICKS_W-1:0] off_s1;
	logic [TICKS_W-1:0] pause_s1;

	// sequencer state; led_q and busy_q double as the status register
	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [TIMER_WIDTH-1:0] on_q, on_d;
	logic [TIMER_WIDTH-1:0] off_q, off_d;
	logic [TIMER_WIDTH-1:0] pause_q, pause_d;
	logic [CODE_W-1:0]      code_q, code_d;
	logic [REP_W-1:0]       reps_q, reps_d;
	logic [CODE_W-1:0]      blinks_q, blinks_d;
	logic [REP_W-1:0]       reps_done_q, reps_done_d;
	logic                   busy_q, busy_d;
	logic                   led_q, led_d;
	logic                   out_valid_q;

	logic                   adv;
	logic                   step;
	logic                   in_acc;
	logic [CODE_W-1:0]      blinks_inc;
	logic [REP_W-1:0]       reps_inc;
	logic                   timer_zero;

	assign adv       = !out_valid_q || rsp.ready;
	assign step      = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;
	assign in_acc    = cmd.valid && cmd.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.led_on   = led_q;
	assign rsp.busy_res = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the input stage, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1    <= cmd.func;
			code_s1    <= cmd.code;
			repeats_s1 <= cmd.repeats;
			on_s1      <= cmd.on_ticks;
			off_s1     <= cmd.off_ticks;
			pause_s1   <= cmd.pause_ticks;
		end
	end

	assign blinks_inc = blinks_q + CODE_W'(1);
	assign reps_inc   = reps_done_q + REP_W'(1);
	assign timer_zero = (timer_q == '0);

	always_comb begin
		phase_d     = phase_q;
		timer_d     = timer_q;
		on_d        = on_q;
		off_d       = off_q;
		pause_d     = pause_q;
		code_d      = code_q;
		reps_d      = reps_q;
		blinks_d    = blinks_q;
		reps_done_d = reps_done_q;
		busy_d      = busy_q;
		led_d       = led_q;
		if (func_s1 == FUNC_LOAD) begin
			code_d      = code_s1;
			reps_d      = repeats_s1;
			on_d        = TIMER_WIDTH'(on_s1);
			off_d       = TIMER_WIDTH'(off_s1);
			pause_d     = TIMER_WIDTH'(pause_s1);
			phase_d     = PH_START;
			reps_done_d = '0;
			busy_d      = 1'b1;
		end else begin
			case (phase_q)
				PH_START: begin
					timer_d  = on_q;
					blinks_d = '0;
					if (code_q == '0) begin
						led_d   = 1'b0;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_ON;
					end
				end
				PH_ON: begin
					led_d = 1'b1;
					if (!timer_zero) begin
						timer_d = timer_q - TIMER_WIDTH'(1);
					end else begin
						timer_d = off_q;
						phase_d = PH_OFF;
					end
				end
				PH_OFF: begin
					led_d = 1'b0;
					if (!timer_zero) begin
						timer_d = timer_q - TIMER_WIDTH'(1);
					end else begin
						blinks_d = blinks_inc;
						if (blinks_inc < code_q) begin
							timer_d = on_q;
							phase_d = PH_ON;
						end else begin
							timer_d = pause_q;
							phase_d = PH_PAUSE;
						end
					end
				end
				PH_PAUSE: begin
					led_d = 1'b0;
					if (!timer_zero) begin
						timer_d = timer_q - TIMER_WIDTH'(1);
					end else begin
						reps_done_d = reps_inc;
						if (reps_q == '0) begin
							phase_d = PH_START;
							busy_d  = 1'b0;
						end else if (reps_inc < reps_q) begin
							phase_d = PH_START;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: begin
					busy_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			on_q        <= '0;
			off_q       <= '0;
			pause_q     <= '0;
			code_q      <= '0;
			reps_q      <= '0;
			blinks_q    <= '0;
			reps_done_q <= '0;
			busy_q      <= 1'b0;
			led_q       <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			timer_q     <= timer_d;
			on_q        <= on_d;
			off_q       <= off_d;
			pause_q     <= pause_d;
			code_q      <= code_d;
			reps_q      <= reps_d;
			blinks_q    <= blinks_d;
			reps_done_q <= reps_done_d;
			busy_q      <= busy_d;
			led_q       <= led_d;
		end
	end

`ifndef SYNTHESIS
	// a load restarts the sequence with busy set
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func_s1 == FUNC_LOAD) |=> (busy_q && phase_q == PH_START))
		else $error("load did not restart the sequence");

	// a load leaves the LED level alone
	a_load_keeps_led: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func_s1 == FUNC_LOAD) |=> (led_q == $past(led_q)))
		else $error("LED level changed on a load");

	// blink count stays below the code while blinking
	a_blinks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ON || phase_q == PH_OFF) |-> (blinks_q < code_q))
		else $error("blink count out of range");

	// on timer never exceeds the loaded on count
	a_on_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ON) |-> (timer_q <= on_q))
		else $error("on timer above its reload value");

	// state moves only when a word is processed
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(timer_q) && $stable(led_q))
		else $error("sequencer state moved without a word");
`endif

endmodule

`default_nettype wire
